// ===== design/mtbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mtbs_pkg
// Types and constants shared by the token bucket sender modules.
// ----------------------------------------------------------------------------
package mtbs_pkg;

    localparam int unsigned LEVEL_W = 40;
    localparam int unsigned FRAC_SHIFT = 8;

    typedef enum logic [0:0] {
        FUNC_ENQ  = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        EV_SENT    = 2'd0,
        EV_ENQ_OK  = 2'd1,
        EV_DROPPED = 2'd2,
        EV_IDLE    = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        REG_RATE0    = 3'd0,
        REG_RATE1    = 3'd1,
        REG_RATE2    = 3'd2,
        REG_CAP      = 3'd3,
        REG_OVERHEAD = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [0:0]  func;
        logic [1:0]  traffic_class;
        logic [15:0] message_bytes;
        logic [15:0] destination_mask;
        logic [7:0]  message_tag;
        logic [19:0] elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [1:0] sent_class;
        logic [4:0] destination_server;
        logic [7:0] sent_tag;
        logic       message_finished;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [23:0] rate0;
        logic [23:0] rate1;
        logic [23:0] rate2;
        logic [31:0] cap_bits;
        logic [7:0]  overhead;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ,
        ST_REFILL_MUL,
        ST_REFILL_ADD,
        ST_SVC_RD,
        ST_SVC_WAIT,
        ST_SVC_EVAL,
        ST_SVC_NEXT,
        ST_EMIT,
        ST_DONE
    } t_state;

endpackage

// ===== design/multiclass_token_bucket_sender.sv =====
// ----------------------------------------------------------------------------
// multiclass_token_bucket_sender
// Three-class token bucket sender with strict priority service.
// ----------------------------------------------------------------------------
// Requests wait in a two-entry queue ahead of the engine, which takes one at a
// time. An enqueue occupies the engine in its own state. A tick starts, runs
// the refill multiply and add for each class, reads and judges each head message
// and sends to its destinations, closes each class and finishes; a head message
// with no destinations left is popped and the next head is read. The engine waits
// whenever a stalled result register blocks it. Each send result is held back
// until the next send or the end of the tick so the final one can carry last.
module multiclass_token_bucket_sender #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned MAX_SERVERS = 16,
    parameter int unsigned NUM_CLASSES = 3,
    parameter int unsigned MAX_SENDS_PER_TICK = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mtbs_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output mtbs_pkg::t_out_item o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    mtbs_pkg::t_cfg r_cfg;
    mtbs_pkg::t_in_item w_q_item;
    logic w_q_valid, w_q_ready;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate0 <= 24'd2560;
            r_cfg.rate1 <= 24'd2560;
            r_cfg.rate2 <= 24'd2560;
            r_cfg.cap_bits <= 32'd1000000;
            r_cfg.overhead <= 8'd0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                mtbs_pkg::REG_RATE0:    r_cfg.rate0 <= pwdata[23:0];
                mtbs_pkg::REG_RATE1:    r_cfg.rate1 <= pwdata[23:0];
                mtbs_pkg::REG_RATE2:    r_cfg.rate2 <= pwdata[23:0];
                mtbs_pkg::REG_CAP:      r_cfg.cap_bits <= pwdata;
                mtbs_pkg::REG_OVERHEAD: r_cfg.overhead <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_idx)
            mtbs_pkg::REG_RATE0:    prdata = {8'h00, r_cfg.rate0};
            mtbs_pkg::REG_RATE1:    prdata = {8'h00, r_cfg.rate1};
            mtbs_pkg::REG_RATE2:    prdata = {8'h00, r_cfg.rate2};
            mtbs_pkg::REG_CAP:      prdata = r_cfg.cap_bits;
            mtbs_pkg::REG_OVERHEAD: prdata = {24'h0, r_cfg.overhead};
            default:                prdata = '0;
        endcase
    end

    mtbs_in_queue #(.DEPTH(2)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_item(w_q_item)
    );

    mtbs_engine #(
        .QUEUE_DEPTH(QUEUE_DEPTH), .MAX_SERVERS(MAX_SERVERS),
        .NUM_CLASSES(NUM_CLASSES), .MAX_SENDS_PER_TICK(MAX_SENDS_PER_TICK)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_item(w_q_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );
endmodule

// ===== design/mtbs_in_queue.sv =====
// ----------------------------------------------------------------------------
// mtbs_in_queue
// Front end: a short request queue between the input port and the engine.
// ----------------------------------------------------------------------------
module mtbs_in_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mtbs_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output mtbs_pkg::t_in_item  o_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mtbs_pkg::t_in_item r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != AW'(0) + (AW+1)'(DEPTH)) ? 1'b1 : 1'b0;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // store a request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

// ===== design/mtbs_engine.sv =====
// ----------------------------------------------------------------------------
// mtbs_engine
// Back end: class queues, buckets, refill and strict priority service.
// ----------------------------------------------------------------------------
module mtbs_engine #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned MAX_SERVERS = 16,
    parameter int unsigned NUM_CLASSES = 3,
    parameter int unsigned MAX_SENDS_PER_TICK = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtbs_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  mtbs_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output mtbs_pkg::t_out_item o_item
);
    localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int unsigned NW = $clog2(NUM_CLASSES * QUEUE_DEPTH);
    localparam int unsigned KW = $clog2(MAX_SENDS_PER_TICK + 1);
    localparam int unsigned SW = (MAX_SERVERS >= 16) ? 16 : MAX_SERVERS;
    localparam int unsigned LW = mtbs_pkg::LEVEL_W;

    // message memory: one row per slot
    logic [15:0] r_size_mem [NUM_CLASSES * QUEUE_DEPTH];
    logic [15:0] r_mask_mem [NUM_CLASSES * QUEUE_DEPTH];
    logic [7:0]  r_tag_mem  [NUM_CLASSES * QUEUE_DEPTH];

    logic [LW-1:0] r_level [NUM_CLASSES];
    logic [QW-1:0] r_head  [NUM_CLASSES];
    logic [QW:0]   r_count [NUM_CLASSES];

    mtbs_pkg::t_state r_state, n_state;
    mtbs_pkg::t_in_item r_req;
    logic [CW-1:0] r_cls;
    logic [KW-1:0] r_sends;
    logic [43:0]   r_prod;
    logic [15:0]   r_rd_size, r_rd_mask;
    logic [7:0]    r_rd_tag;
    logic          r_out_valid;
    mtbs_pkg::t_out_item r_out;
    mtbs_pkg::t_out_item r_pend;
    logic          r_pend_valid;
    logic [NW-1:0] r_addr;

    logic          w_drop;
    logic [QW:0]   w_tail_sum;
    logic [QW-1:0] w_tail;
    logic [23:0]   w_rate;
    logic [44:0]   w_sum;
    logic [LW-1:0] w_cap, w_need;
    logic [3:0]    w_k;
    logic [15:0]   w_newmask;
    logic          w_last_cls;
    logic          w_out_free;
    logic          w_out_load;
    mtbs_pkg::t_out_item w_pend_last;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign o_ready = (r_state == mtbs_pkg::ST_IDLE);

    assign w_drop = (32'(r_req.traffic_class) >= NUM_CLASSES)
        || (r_count[r_req.traffic_class[CW-1:0]] >= (QW+1)'(QUEUE_DEPTH));
    assign w_tail_sum = (QW+1)'(r_head[r_req.traffic_class[CW-1:0]])
        + r_count[r_req.traffic_class[CW-1:0]];
    assign w_tail = (w_tail_sum >= (QW+1)'(QUEUE_DEPTH))
        ? QW'(w_tail_sum - (QW+1)'(QUEUE_DEPTH)) : w_tail_sum[QW-1:0];

    always_comb begin
        case (r_cls)
            CW'(0):  w_rate = i_cfg.rate0;
            CW'(1):  w_rate = (NUM_CLASSES > 1) ? i_cfg.rate1 : i_cfg.rate0;
            default: w_rate = i_cfg.rate2;
        endcase
    end
    assign w_cap  = {i_cfg.cap_bits, 8'h00};
    assign w_sum  = 45'(r_level[r_cls]) + 45'(r_prod);
    assign w_need = LW'({17'(r_rd_size) + 17'(i_cfg.overhead), 11'h000});
    assign w_last_cls = (32'(r_cls) == NUM_CLASSES - 1);

    // lowest pending destination
    always_comb begin
        w_k = 4'd15;
        for (int i = 15; i >= 0; i--) begin
            if (r_rd_mask[i]) begin
                w_k = 4'(i);
            end
        end
    end
    assign w_newmask = r_rd_mask & ~(16'd1 << w_k);

    // final send of a tick carries last
    always_comb begin
        w_pend_last = r_pend;
        w_pend_last.last = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtbs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_item.func == mtbs_pkg::FUNC_TICK)
                        ? mtbs_pkg::ST_REFILL_MUL : mtbs_pkg::ST_ENQ;
                end
            end
            mtbs_pkg::ST_ENQ: if (w_out_free) n_state = mtbs_pkg::ST_IDLE;
            mtbs_pkg::ST_REFILL_MUL: n_state = mtbs_pkg::ST_REFILL_ADD;
            mtbs_pkg::ST_REFILL_ADD: n_state = w_last_cls
                ? mtbs_pkg::ST_SVC_RD : mtbs_pkg::ST_REFILL_MUL;
            mtbs_pkg::ST_SVC_RD: begin
                if (r_count[r_cls] == '0 || 32'(r_sends) >= MAX_SENDS_PER_TICK) begin
                    n_state = mtbs_pkg::ST_SVC_NEXT;
                end else begin
                    n_state = mtbs_pkg::ST_SVC_WAIT;
                end
            end
            mtbs_pkg::ST_SVC_WAIT: n_state = mtbs_pkg::ST_SVC_EVAL;
            mtbs_pkg::ST_SVC_EVAL: begin
                if (r_rd_mask == '0) begin
                    n_state = mtbs_pkg::ST_SVC_RD;
                end else if (r_level[r_cls] < w_need) begin
                    n_state = mtbs_pkg::ST_SVC_NEXT;
                end else begin
                    n_state = mtbs_pkg::ST_EMIT;
                end
            end
            mtbs_pkg::ST_EMIT: if (w_out_free) n_state = mtbs_pkg::ST_SVC_RD;
            mtbs_pkg::ST_SVC_NEXT: n_state = w_last_cls
                ? mtbs_pkg::ST_DONE : mtbs_pkg::ST_SVC_RD;
            mtbs_pkg::ST_DONE: if (w_out_free) n_state = mtbs_pkg::ST_IDLE;
            default: n_state = mtbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // memory port: write on enqueue or send, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == mtbs_pkg::ST_ENQ && w_out_free && !w_drop) begin
            r_size_mem[NW'(32'(r_req.traffic_class[CW-1:0]) * QUEUE_DEPTH + 32'(w_tail))]
                <= r_req.message_bytes;
            r_mask_mem[NW'(32'(r_req.traffic_class[CW-1:0]) * QUEUE_DEPTH + 32'(w_tail))]
                <= r_req.destination_mask & 16'((17'd1 << SW) - 17'd1);
            r_tag_mem[NW'(32'(r_req.traffic_class[CW-1:0]) * QUEUE_DEPTH + 32'(w_tail))]
                <= r_req.message_tag;
        end else if (r_state == mtbs_pkg::ST_EMIT && w_out_free) begin
            r_mask_mem[r_addr] <= w_newmask;
        end
        if (r_state == mtbs_pkg::ST_SVC_RD) begin
            r_addr <= NW'(32'(r_cls) * QUEUE_DEPTH + 32'(r_head[r_cls]));
        end
        if (r_state == mtbs_pkg::ST_SVC_WAIT) begin
            r_rd_size <= r_size_mem[r_addr];
            r_rd_mask <= r_mask_mem[r_addr];
            r_rd_tag  <= r_tag_mem[r_addr];
        end
    end

    // load the result register, drop it once taken
    assign w_out_load = w_out_free && ((r_state == mtbs_pkg::ST_ENQ)
        || (r_state == mtbs_pkg::ST_DONE)
        || (r_state == mtbs_pkg::ST_EMIT && r_pend_valid));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls <= '0;
            r_sends <= '0;
            r_pend_valid <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_level[c] <= '0;
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
        end else begin
            case (r_state)
                mtbs_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_item;
                        r_cls <= '0;
                        r_sends <= '0;
                    end
                end
                mtbs_pkg::ST_ENQ: begin
                    if (w_out_free) begin
                        r_out.event_kind <= w_drop ? mtbs_pkg::EV_DROPPED
                                                   : mtbs_pkg::EV_ENQ_OK;
                        r_out.sent_class <= r_req.traffic_class;
                        r_out.destination_server <= '0;
                        r_out.sent_tag <= r_req.message_tag;
                        r_out.message_finished <= 1'b0;
                        r_out.last <= 1'b1;
                        if (!w_drop) begin
                            r_count[r_req.traffic_class[CW-1:0]] <=
                                r_count[r_req.traffic_class[CW-1:0]] + 1'b1;
                        end
                    end
                end
                mtbs_pkg::ST_REFILL_MUL: r_prod <= 44'(w_rate) * 44'(r_req.elapsed_us);
                mtbs_pkg::ST_REFILL_ADD: begin
                    r_level[r_cls] <= (w_sum > 45'(w_cap)) ? w_cap : w_sum[LW-1:0];
                    r_cls <= w_last_cls ? '0 : r_cls + 1'b1;
                end
                mtbs_pkg::ST_SVC_EVAL: begin
                    if (r_rd_mask == '0) begin
                        r_head[r_cls] <= (r_head[r_cls] == QW'(QUEUE_DEPTH - 1))
                            ? '0 : r_head[r_cls] + 1'b1;
                        r_count[r_cls] <= r_count[r_cls] - 1'b1;
                    end
                end
                mtbs_pkg::ST_EMIT: begin
                    if (w_out_free) begin
                        r_level[r_cls] <= r_level[r_cls] - w_need;
                        // release the previous send, keep this one back
                        if (r_pend_valid) begin
                            r_out <= r_pend;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend.event_kind <= mtbs_pkg::EV_SENT;
                        r_pend.sent_class <= 2'(r_cls);
                        r_pend.destination_server <= 5'(w_k) + 5'd1;
                        r_pend.sent_tag <= r_rd_tag;
                        r_pend.message_finished <= (w_newmask == '0);
                        r_pend.last <= 1'b0;
                        r_sends <= r_sends + 1'b1;
                        if (w_newmask == '0) begin
                            r_head[r_cls] <= (r_head[r_cls] == QW'(QUEUE_DEPTH - 1))
                                ? '0 : r_head[r_cls] + 1'b1;
                            r_count[r_cls] <= r_count[r_cls] - 1'b1;
                        end
                    end
                end
                mtbs_pkg::ST_SVC_NEXT: r_cls <= w_last_cls ? r_cls : r_cls + 1'b1;
                mtbs_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_pend_valid <= 1'b0;
                        if (r_pend_valid) begin
                            r_out <= w_pend_last;
                        end else begin
                            r_out.event_kind <= mtbs_pkg::EV_IDLE;
                            r_out.sent_class <= '0;
                            r_out.destination_server <= '0;
                            r_out.sent_tag <= '0;
                            r_out.message_finished <= 1'b0;
                            r_out.last <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
